/* hw/rtl/sfd_pkg.sv */
// Shared constants and types for the stereo feedback delay.
package sfd_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_FRAMES_DEF  = 524288;
  localparam int SAMPLE_BITS_DEF = 24;

  // Q1.15 gain format.
  localparam int GAIN_W     = 16;
  localparam int GAIN_ONE   = 32768;
  localparam int ROUND_HALF = 16384;
  localparam int Q_SHIFT    = 15;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;

  // Register reset values.
  localparam int DELAY_LENGTH_RST  = 18000;
  localparam int FEEDBACK_GAIN_RST = 24576;
  localparam int DRY_GAIN_RST      = 32768;
  localparam int WET_GAIN_RST      = 24576;

  // Output queue depth; it also bounds the requests in flight.
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH  = 8'd0,
    REG_FEEDBACK_GAIN = 8'd1,
    REG_DRY_GAIN      = 8'd2,
    REG_WET_GAIN      = 8'd3
  } reg_index_t;

endpackage

/* hw/rtl/sfd_out_fifo.sv */
// Small output queue that holds finished frames until the receiver takes them.
module sfd_out_fifo #(
  parameter int DATA_W = 2 * sfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_data
);
  import sfd_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [DATA_W-1:0] slots [FIFO_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;

  // Pointers and fill level; the producer never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PTR_W'(1);
      if (pop)  rptr <= rptr + PTR_W'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  assign out_valid = (count != '0);
  assign out_data  = slots[rptr];

endmodule

/* hw/rtl/stereo_feedback_delay.sv */
// Stereo feedback delay: circular frame store with feedback and dry/wet mix.
//
// Input frames arrive on the s_axis channel (left and right samples in tdata),
// mixed frames leave on the m_axis channel in the same order, one per input.
// Registers are written through the cfg channel (index, data), which is always
// ready; write only while no request is in flight.
// A frame accepted on s_axis passes stage one, stage two and the output queue.
// Throughput is one frame per cycle, set by the single read-modify-write of the
// delay memory per frame (read at acceptance, write from the last stage), while
// no slot hazard or full queue holds s_axis_tready low. With a delay length of
// one, every frame hits the slot its predecessor is still computing and waits.
// The output queue holds four frames; when the receiver stalls, s_axis_tready
// drops once four frames are accepted but not yet taken, and nothing is lost.
// Reset sets the registers to their defaults and the position to zero. The
// memory is not swept: a fill count marks the slots written since reset, and
// the others read as silence, so the block is ready right after reset.
module stereo_feedback_delay #(
  parameter int MAX_FRAMES  = sfd_pkg::MAX_FRAMES_DEF,
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input frames.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // From bit 0: left_in, right_in, zero pad to whole bytes.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Mixed frames.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // From bit 0: left_out, right_out, zero pad to whole bytes.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // Register writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sfd_pkg::*;

  localparam int S     = SAMPLE_BITS;
  localparam int FW    = 2 * S;
  localparam int DW    = ((FW + 7) / 8) * 8;
  localparam int AW    = $clog2(MAX_FRAMES);
  localparam int LW    = $clog2(MAX_FRAMES + 1);
  localparam int PW    = S + GAIN_W + 1;
  localparam int XW    = PW + 2;
  localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

  // Delay length seen by the datapath: zero acts as one, oversize as the maximum.
  function automatic logic [LW-1:0] eff_len_f(input logic [CFG_DATA_W-1:0] dl);
    logic [LW-1:0] r;
    if (dl == '0) begin
      r = LW'(1);
    end else if (32'(dl) > 32'(MAX_FRAMES)) begin
      r = LW'(MAX_FRAMES);
    end else begin
      r = LW'(dl);
    end
    return r;
  endfunction

  // Clamp a wide signed value to a signed sample.
  function automatic logic [S-1:0] sat_f(input logic signed [XW-1:0] v);
    logic [XW-S:0] hi;
    logic [S-1:0]  r;
    hi = v[XW-1:S-1];
    if ((&hi) || !(|hi)) begin
      r = v[S-1:0];
    end else if (v[XW-1]) begin
      r = {1'b1, {(S-1){1'b0}}};
    end else begin
      r = {1'b0, {(S-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] clamp_gain_f(input logic [GAIN_W-1:0] g);
    return (g > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : g;
  endfunction

  // Configuration registers and frame position.
  logic [CFG_DATA_W-1:0] delay_length;
  logic [GAIN_W-1:0]     feedback_gain;
  logic [GAIN_W-1:0]     dry_gain;
  logic [GAIN_W-1:0]     wet_gain;
  logic [AW-1:0]         position;
  logic [AW-1:0]         position_next;
  logic [LW-1:0]         fill;
  logic [LW-1:0]         eff_len;
  logic [LW-1:0]         pos_inc;

  // Pipeline registers.
  logic                  s1_valid;
  logic [AW-1:0]         s1_addr;
  logic                  s1_fresh;
  logic signed [S-1:0]   s1_in_l;
  logic signed [S-1:0]   s1_in_r;
  logic [FW-1:0]         rdata;
  logic                  s2_valid;
  logic [AW-1:0]         s2_addr;
  logic signed [S-1:0]   s2_in_l;
  logic signed [S-1:0]   s2_in_r;
  logic signed [PW-1:0]  s2_fb_l;
  logic signed [PW-1:0]  s2_fb_r;
  logic signed [PW-1:0]  s2_dry_l;
  logic signed [PW-1:0]  s2_dry_r;
  logic signed [PW-1:0]  s2_wet_l;
  logic signed [PW-1:0]  s2_wet_r;
  logic                  last_wr_valid;
  logic [AW-1:0]         last_wr_addr;
  logic [FW-1:0]         last_wr_data;

  logic [FW-1:0]         mem [MAX_FRAMES];

  logic                  s_accept;
  logic                  m_accept;
  logic                  hazard;
  logic [PEND_W-1:0]     pending;
  logic [FW-1:0]         d_word;
  logic signed [S-1:0]   d_l;
  logic signed [S-1:0]   d_r;
  logic signed [XW-1:0]  fbq_l;
  logic signed [XW-1:0]  fbq_r;
  logic signed [XW-1:0]  mix_l;
  logic signed [XW-1:0]  mix_r;
  logic [FW-1:0]         wr_word;
  logic [FW-1:0]         out_word;
  logic [FW-1:0]         fifo_data;

  assign cfg_ready = 1'b1;
  assign eff_len   = eff_len_f(delay_length);
  assign pos_inc   = LW'(position) + LW'(1);
  assign position_next = (pos_inc >= eff_len) ? '0 : AW'(pos_inc);

  // A request whose slot is still being computed one stage ahead is held back.
  assign hazard        = s1_valid && (s1_addr == position);
  assign s_axis_tready = (pending < PEND_W'(FIFO_DEPTH)) && !hazard;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;

  // Register writes, position and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length  <= CFG_DATA_W'(DELAY_LENGTH_RST);
      feedback_gain <= GAIN_W'(FEEDBACK_GAIN_RST);
      dry_gain      <= GAIN_W'(DRY_GAIN_RST);
      wet_gain      <= GAIN_W'(WET_GAIN_RST);
      position      <= '0;
      fill          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DELAY_LENGTH: begin
            delay_length <= cfg_data;
            if (LW'(position) >= eff_len_f(cfg_data)) position <= '0;
          end
          REG_FEEDBACK_GAIN: feedback_gain <= clamp_gain_f(cfg_data[GAIN_W-1:0]);
          REG_DRY_GAIN:      dry_gain      <= clamp_gain_f(cfg_data[GAIN_W-1:0]);
          REG_WET_GAIN:      wet_gain      <= clamp_gain_f(cfg_data[GAIN_W-1:0]);
          default: ;
        endcase
      end
      if (s_accept) begin
        position <= position_next;
        if (LW'(position) == fill) fill <= fill + LW'(1);
      end
    end
  end

  // Requests accepted but not yet taken at the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PEND_W'(s_accept) - PEND_W'(m_accept);
    end
  end

  // Delay memory: one read at acceptance, one write from the last stage.
  always_ff @(posedge clk) begin
    if (s_accept) rdata <= mem[position];
  end

  always_ff @(posedge clk) begin
    if (s2_valid) mem[s2_addr] <= wr_word;
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      last_wr_valid <= 1'b0;
    end else begin
      s1_valid      <= s_accept;
      s2_valid      <= s1_valid;
      last_wr_valid <= s2_valid;
    end
  end

  // Stage one capture: input samples, slot and whether it was written since reset.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_addr  <= position;
      s1_fresh <= (LW'(position) < fill);
      s1_in_l  <= s_axis_tdata[S-1:0];
      s1_in_r  <= s_axis_tdata[FW-1:S];
    end
  end

  // Delayed frame: a write that landed at the same edge as the read is forwarded.
  always_comb begin
    if (last_wr_valid && (last_wr_addr == s1_addr)) begin
      d_word = last_wr_data;
    end else if (s1_fresh) begin
      d_word = rdata;
    end else begin
      d_word = '0;
    end
  end

  assign d_l = d_word[S-1:0];
  assign d_r = d_word[FW-1:S];

  // Stage two: gain products.
  always_ff @(posedge clk) begin
    s2_addr  <= s1_addr;
    s2_in_l  <= s1_in_l;
    s2_in_r  <= s1_in_r;
    s2_fb_l  <= PW'(d_l) * PW'($signed({1'b0, feedback_gain}));
    s2_fb_r  <= PW'(d_r) * PW'($signed({1'b0, feedback_gain}));
    s2_dry_l <= PW'(s1_in_l) * PW'($signed({1'b0, dry_gain}));
    s2_dry_r <= PW'(s1_in_r) * PW'($signed({1'b0, dry_gain}));
    s2_wet_l <= PW'(d_l) * PW'($signed({1'b0, wet_gain}));
    s2_wet_r <= PW'(d_r) * PW'($signed({1'b0, wet_gain}));
  end

  // Rounding, sums and saturation for the store and the output.
  assign fbq_l = (XW'(s2_fb_l) + XW'(ROUND_HALF)) >>> Q_SHIFT;
  assign fbq_r = (XW'(s2_fb_r) + XW'(ROUND_HALF)) >>> Q_SHIFT;
  assign mix_l = (XW'(s2_dry_l) + XW'(s2_wet_l) + XW'(ROUND_HALF)) >>> Q_SHIFT;
  assign mix_r = (XW'(s2_dry_r) + XW'(s2_wet_r) + XW'(ROUND_HALF)) >>> Q_SHIFT;

  assign wr_word  = {sat_f(fbq_r + XW'(s2_in_r)), sat_f(fbq_l + XW'(s2_in_l))};
  assign out_word = {sat_f(mix_r), sat_f(mix_l)};

  // Last write, kept for forwarding.
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      last_wr_addr <= s2_addr;
      last_wr_data <= wr_word;
    end
  end

  sfd_out_fifo #(
    .DATA_W (FW)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (out_word),
    .pop       (m_accept),
    .out_valid (m_axis_tvalid),
    .out_data  (fifo_data)
  );

  assign m_axis_tdata = DW'(fifo_data);

  // The position stays inside the current delay length.
  assert property (@(posedge clk) disable iff (rst) LW'(position) < eff_len)
    else $error("position beyond delay length");

  // Written slots form a prefix of the memory that reaches the position.
  assert property (@(posedge clk) disable iff (rst) LW'(position) <= fill)
    else $error("position ahead of fill count");

  // An accepted request passes stage one and then reaches the write stage.
  assert property (@(posedge clk) disable iff (rst) s_accept |=> s1_valid ##1 s2_valid)
    else $error("request lost in pipeline");

  // Requests in flight never exceed the output queue.
  assert property (@(posedge clk) disable iff (rst) pending <= PEND_W'(FIFO_DEPTH))
    else $error("output queue overrun");

  // No output is offered with nothing pending.
  assert property (@(posedge clk) disable iff (rst) (pending == '0) |-> !m_axis_tvalid)
    else $error("output without request");

endmodule

/* dv/sfd_checker.sv */
// Watches the stereo feedback delay channels, predicts every mixed frame and compares it.
module sfd_checker #(
  parameter int MAX_FRAMES  = sfd_pkg::MAX_FRAMES_DEF,
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF,
  parameter int DATA_W      = ((2*SAMPLE_BITS+7)/8)*8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // From bit 0: left_in, right_in, zero pad.
  input  logic [DATA_W-1:0]             s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // From bit 0: left_out, right_out, zero pad.
  input  logic [DATA_W-1:0]             m_axis_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            backlog
);
  import sfd_pkg::*;

  // Left sample sits in the low bits, as on the bus.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] left;
  } frame_t;

  // Shadow copy of the registers, the echo memory and the write position.
  logic [CFG_DATA_W-1:0] delay_len;
  logic [GAIN_W-1:0]     feedback_q15;
  logic [GAIN_W-1:0]     dry_q15;
  logic [GAIN_W-1:0]     wet_q15;
  int unsigned           write_pos;
  frame_t                echo_mem [int unsigned];
  frame_t                expected_mix [$];
  int                    fails;

  function automatic longint clip(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_BITS-1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // A zero length behaves as one; anything above the memory size as the size.
  function automatic int unsigned span();
    if (delay_len == 0) return 1;
    if (delay_len > MAX_FRAMES) return MAX_FRAMES;
    return 32'(delay_len);
  endfunction

  function automatic logic [GAIN_W-1:0] limit_gain(logic [GAIN_W-1:0] g);
    return (g > GAIN_ONE) ? GAIN_W'(GAIN_ONE) : g;
  endfunction

  // Value written back into the slot: input plus the scaled echo.
  function automatic longint feed(longint x, longint d);
    longint g;
    g = longint'(feedback_q15);
    return clip(x + ((d * g + ROUND_HALF) >>> Q_SHIFT));
  endfunction

  // Output sample: dry input and wet echo summed, rounded once.
  function automatic longint blend(longint x, longint d);
    longint gd;
    longint gw;
    gd = longint'(dry_q15);
    gw = longint'(wet_q15);
    return clip((x * gd + d * gw + ROUND_HALF) >>> Q_SHIFT);
  endfunction

  // One read-modify-write of the echo memory; returns the mixed frame.
  function automatic frame_t mix_frame(frame_t x);
    int unsigned n;
    int unsigned p;
    frame_t      d;
    frame_t      w;
    frame_t      y;
    n = span();
    p = (write_pos < n) ? write_pos : 0;
    d = echo_mem.exists(p) ? echo_mem[p] : '0;
    w.left  = SAMPLE_BITS'(feed(x.left, d.left));
    w.right = SAMPLE_BITS'(feed(x.right, d.right));
    y.left  = SAMPLE_BITS'(blend(x.left, d.left));
    y.right = SAMPLE_BITS'(blend(x.right, d.right));
    echo_mem[p] = w;
    p = p + 1;
    if (p >= n) p = 0;
    write_pos = p;
    return y;
  endfunction

  always @(posedge clk) begin : watch
    frame_t got;
    frame_t want;
    if (rst) begin
      delay_len    = CFG_DATA_W'(DELAY_LENGTH_RST);
      feedback_q15 = GAIN_W'(FEEDBACK_GAIN_RST);
      dry_q15      = GAIN_W'(DRY_GAIN_RST);
      wet_q15      = GAIN_W'(WET_GAIN_RST);
      write_pos    = 0;
      echo_mem.delete();
      expected_mix.delete();
      fails = 0;
    end else begin
      // Register writes; unused indexes leave everything as it was.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DELAY_LENGTH: begin
            delay_len = cfg_data;
            if (write_pos >= span()) write_pos = 0;
          end
          REG_FEEDBACK_GAIN: feedback_q15 = limit_gain(cfg_data[GAIN_W-1:0]);
          REG_DRY_GAIN:      dry_q15 = limit_gain(cfg_data[GAIN_W-1:0]);
          REG_WET_GAIN:      wet_q15 = limit_gain(cfg_data[GAIN_W-1:0]);
          default: ;
        endcase
      end

      // Every accepted request yields exactly one mixed frame.
      if (s_axis_tvalid && s_axis_tready)
        expected_mix.push_back(mix_frame(frame_t'(s_axis_tdata[2*SAMPLE_BITS-1:0])));

      // Compare each taken frame with the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        got = frame_t'(m_axis_tdata[2*SAMPLE_BITS-1:0]);
        if (expected_mix.size() == 0) begin
          $error("unexpected mixed frame: left_out %0d, right_out %0d", got.left, got.right);
          fails++;
        end else begin
          want = expected_mix.pop_front();
          if (got.left !== want.left) begin
            $error("left_out mismatch: expected %0d, actual %0d", want.left, got.left);
            fails++;
          end
          if (got.right !== want.right) begin
            $error("right_out mismatch: expected %0d, actual %0d", want.right, got.right);
            fails++;
          end
        end
      end
    end
    backlog    <= expected_mix.size();
    fail_count <= fails;
  end

endmodule

/* dv/tb.sv */
// Top of the stereo feedback delay testbench: clock, reset, stimulus and verdict.
module tb;
  import sfd_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int MF          = MAX_FRAMES_DEF;
  localparam int DATA_W      = ((2*SB+7)/8)*8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS    = 5;
  localparam int SEG_FRAMES  = 95;

  localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int backlog;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int settings = 0;

  int phase_idle  [4] = '{0, 50, 0, 27};
  int phase_stall [4] = '{0, 0, 50, 27};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stereo_feedback_delay u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  sfd_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .backlog       (backlog)
  );

  // Sink side stalls at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one frame after a random gap and waits until it is taken.
  // Valid stays high afterwards so back-to-back requests need no bubble.
  task automatic send_frame(input logic [SB-1:0] l, input logic [SB-1:0] r);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'({r, l});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // Drops valid and waits until every predicted frame has come back.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  // Leaves valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] len, input logic [CFG_DATA_W-1:0] fb,
                           input logic [CFG_DATA_W-1:0] dry, input logic [CFG_DATA_W-1:0] wet);
    quiesce();
    write_reg(REG_DELAY_LENGTH, len);
    write_reg(REG_FEEDBACK_GAIN, fb);
    write_reg(REG_DRY_GAIN, dry);
    write_reg(REG_WET_GAIN, wet);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Writes to indexes past the register list must be ignored.
  task automatic poke_unused();
    quiesce();
    write_reg(CFG_IDX_W'($urandom_range(4, 254)), CFG_DATA_W'($urandom));
    write_reg('1, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SB'(int'($urandom_range(8)) - 4);
      default: return SB'($urandom);
    endcase
  endfunction

  // Mostly short delays so the echo comes around many times per segment.
  function automatic logic [CFG_DATA_W-1:0] pick_length();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(MF);
      3:       return '1;
      4:       return CFG_DATA_W'($urandom);
      5, 6:    return CFG_DATA_W'($urandom_range(2, 16));
      default: return CFG_DATA_W'($urandom_range(17, 400));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CFG_DATA_W'(GAIN_ONE);
      2:       return CFG_DATA_W'(16'hFFFF);
      3:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, GAIN_ONE));
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults against a silent memory.
    send_frame(S_MAX, S_MAX);
    send_frame(S_MIN, S_MIN);

    // Short loop at unity gains so feedback and output saturate; the
    // feedback gain is written above 1.0.
    configure(CFG_DATA_W'(3), CFG_DATA_W'(16'hFFFF), CFG_DATA_W'(GAIN_ONE),
              CFG_DATA_W'(GAIN_ONE));
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame(S_MAX, S_MAX);
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame(S_MAX, S_MAX);

    // Zero length acts as one; gain bits above bit 15 are dropped, and the
    // tiny samples land on half-step rounding.
    poke_unused();
    configure('0, CFG_DATA_W'(16384), 20'h1_0001, 20'h1_4000);
    send_frame(SB'(1), SB'(-1));
    send_frame(SB'(-1), SB'(1));
    send_frame(SB'(3), SB'(-3));
    send_frame('0, '0);

    // Lengths past the memory size, then exactly the memory size.
    configure('1, CFG_DATA_W'(24576), CFG_DATA_W'(GAIN_ONE), CFG_DATA_W'(24576));
    repeat (3) send_frame(pick_sample(), pick_sample());
    configure(CFG_DATA_W'(MF), '0, '0, CFG_DATA_W'(GAIN_ONE));
    repeat (2) send_frame(pick_sample(), pick_sample());

    // Shrinking the length below the position pulls it back to slot zero.
    configure(CFG_DATA_W'(16), CFG_DATA_W'(20000), CFG_DATA_W'(12000), CFG_DATA_W'(30000));
    repeat (6) send_frame(pick_sample(), pick_sample());
    configure(CFG_DATA_W'(2), CFG_DATA_W'(20000), CFG_DATA_W'(12000), CFG_DATA_W'(30000));
    repeat (3) send_frame(pick_sample(), pick_sample());

    // Random settings under each pacing mix.
    for (int ph = 0; ph < 4; ph++) begin
      quiesce();
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        if ($urandom_range(3) == 0) poke_unused();
        configure(pick_length(), pick_gain(), pick_gain(), pick_gain());
        repeat (SEG_FRAMES) send_frame(pick_sample(), pick_sample());
      end
    end

    quiesce();
    repeat (8) @(posedge clk);

    $display("Run covered %0d frames under %0d register settings,", sent, settings);
    $display("paced with source gaps and sink stalls alone and together.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
